// ===== hw/rtl/csm_pkg.sv =====
// Package for the causal masked softmax row core.
// Holds the fixed field widths and the exp lookup tables; no dependencies.
package csm_pkg;

  localparam int MAX_ROW_DEF = 64;
  localparam int SCORE_W     = 16;
  localparam int QPOS_W      = 6;
  localparam int PROB_W      = 17;
  localparam int COL_W       = 6;
  localparam int SUM_W       = 23;
  localparam int DIV_STEPS   = 17;
  localparam int INT_STEPS   = 12;

  function automatic logic [16:0] exp_int(input logic [3:0] k);
    logic [16:0] v;
    case (k)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] exp_hi(input logic [3:0] h);
    logic [16:0] v;
    case (h)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd61565;
      4'd2:    v = 17'd57835;
      4'd3:    v = 17'd54331;
      4'd4:    v = 17'd51039;
      4'd5:    v = 17'd47947;
      4'd6:    v = 17'd45042;
      4'd7:    v = 17'd42313;
      4'd8:    v = 17'd39750;
      4'd9:    v = 17'd37341;
      4'd10:   v = 17'd35079;
      4'd11:   v = 17'd32954;
      4'd12:   v = 17'd30957;
      4'd13:   v = 17'd29081;
      4'd14:   v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] exp_lo(input logic [3:0] l);
    logic [16:0] v;
    case (l)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd65280;
      4'd2:    v = 17'd65026;
      4'd3:    v = 17'd64772;
      4'd4:    v = 17'd64520;
      4'd5:    v = 17'd64268;
      4'd6:    v = 17'd64018;
      4'd7:    v = 17'd63768;
      4'd8:    v = 17'd63520;
      4'd9:    v = 17'd63272;
      4'd10:   v = 17'd63025;
      4'd11:   v = 17'd62780;
      4'd12:   v = 17'd62535;
      4'd13:   v = 17'd62291;
      4'd14:   v = 17'd62048;
      default: v = 17'd61806;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/csm_exp.sv =====
// Two-stage table exp(-d/256) in unsigned Q1.16.
// Depends on csm_pkg for the lookup tables.
module csm_exp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [15:0] in_d,
  input  logic        in_zero,
  output logic        out_vld,
  output logic [16:0] out_e
);
  import csm_pkg::*;

  logic        v1_r, v2_r;
  logic        z1_r, z2_r;
  logic [3:0]  l1_r;
  logic [33:0] p1_r, p2_r;
  logic [33:0] r1, r2;
  logic [16:0] e1;

  assign r1 = p1_r + 34'd32768;
  assign e1 = r1[32:16];
  assign r2 = p2_r + 34'd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_r <= 34'(exp_int(in_d[11:8]) * exp_hi(in_d[7:4]));
    l1_r <= in_d[3:0];
    z1_r <= in_zero || (in_d[15:8] >= 8'(INT_STEPS));
    p2_r <= 34'(e1 * exp_lo(l1_r));
    z2_r <= z1_r;
  end

  assign out_vld = v2_r;
  assign out_e   = z2_r ? 17'd0 : r2[32:16];

endmodule

// ===== hw/rtl/csm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the weight normalization.
// Depends on csm_pkg for widths.
module csm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [33:0]               num,
  input  logic [csm_pkg::SUM_W-1:0] den,
  output logic                      done,
  output logic [16:0]               quo
);
  import csm_pkg::*;

  logic              busy_r, done_r;
  logic [4:0]        cnt_r;
  logic [SUM_W:0]    rem_r;
  logic [16:0]       nlo_r, q_r;
  logic [SUM_W-1:0]  den_r;
  logic [SUM_W:0]    shl;
  logic [SUM_W+1:0]  trial;

  assign shl   = {rem_r[SUM_W-1:0], nlo_r[16]};
  assign trial = {1'b0, shl} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= (SUM_W+1)'(num[33:17]);
      nlo_r <= num[16:0];
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      nlo_r <= {nlo_r[15:0], 1'b0};
      if (!trial[SUM_W+1]) begin
        rem_r <= trial[SUM_W:0];
        q_r   <= {q_r[15:0], 1'b1};
      end else begin
        rem_r <= shl;
        q_r   <= {q_r[15:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== hw/rtl/causal_masked_softmax_row_core.sv =====
// Causal masked softmax over one attention row: the scores sit in one
// synchronous memory; a pass sums the exponentials, a second pass emits the
// weights. Scores load one per cycle while no row is closing. On the closing
// item the block stalls its input while it reads, differences and exponentiates
// each stored column to sum, then per column reads and exponentiates again, runs
// the serial divider and holds the output transaction through any output stall,
// to emit; the serial divider and the memory read bound each column.
module causal_masked_softmax_row_core #(
  parameter int MAX_ROW = csm_pkg::MAX_ROW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [csm_pkg::SCORE_W-1:0] in_score,
  input  logic [csm_pkg::QPOS_W-1:0]  in_query_position,
  input  logic                       in_last_score,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [csm_pkg::PROB_W-1:0] out_probability,
  output logic [csm_pkg::COL_W-1:0]  out_column,
  output logic                       out_last_weight
);
  import csm_pkg::*;

  localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
  localparam int CW = $clog2(MAX_ROW + 1);

  typedef enum logic [5:0] {
    S_LOAD = 6'b000001,
    S_READ = 6'b000010,
    S_DIFF = 6'b000100,
    S_EXPW = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SCORE_W-1:0]  mem [MAX_ROW];
  logic [SCORE_W-1:0]  rdata_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [QPOS_W-1:0]   qp_r, qp_nxt, qp_eff;
  logic [SCORE_W-1:0]  max_r, max_nxt;
  logic [AW-1:0]       col_r, col_nxt;
  logic                emit_r, emit_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [PROB_W-1:0]   prob_r;
  logic                accept, wr_en, col_last;
  logic [16:0]         diff;
  logic                exp_vld, div_done;
  logic [16:0]         exp_e, quo;
  logic [33:0]         div_num;

  assign accept   = in_valid && (state_r == S_LOAD);
  assign in_stall = (state_r != S_LOAD);
  assign qp_eff   = (cnt_r == '0) ? in_query_position : qp_r;
  assign wr_en    = accept && (cnt_r < CW'(MAX_ROW));
  assign col_last = (CW'(col_r) + CW'(1)) == cnt_r;
  assign diff     = {max_r[15], max_r} - {rdata_r[15], rdata_r};
  assign div_num  = {exp_e, 16'd0} + 34'(sum_r[SUM_W-1:1]);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[AW-1:0]] <= in_score;
    end
    if (state_r == S_READ) begin
      rdata_r <= mem[col_r];
    end
  end

  csm_exp u_exp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (state_r == S_DIFF),
    .in_d    (diff[15:0]),
    .in_zero (diff[16] || (7'(col_r) > {1'b0, qp_r})),
    .out_vld (exp_vld),
    .out_e   (exp_e)
  );

  csm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_EXPW && exp_vld && emit_r),
    .num   (div_num),
    .den   (sum_r),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    qp_nxt    = qp_r;
    max_nxt   = max_r;
    col_nxt   = col_r;
    emit_nxt  = emit_r;
    sum_nxt   = sum_r;
    case (state_r)
      S_LOAD: begin
        if (accept) begin
          qp_nxt = qp_eff;
          if (cnt_r < CW'(MAX_ROW)) begin
            cnt_nxt = cnt_r + CW'(1);
            if (7'(cnt_r) <= {1'b0, qp_eff} && $signed(in_score) > $signed(max_r)) begin
              max_nxt = in_score;
            end
          end
          if (in_last_score) begin
            state_nxt = S_READ;
            col_nxt   = '0;
            emit_nxt  = 1'b0;
            sum_nxt   = '0;
          end
        end
      end
      S_READ: state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_EXPW;
      S_EXPW: begin
        if (exp_vld) begin
          if (emit_r) begin
            state_nxt = S_DIV;
          end else begin
            sum_nxt   = sum_r + SUM_W'(exp_e);
            state_nxt = S_READ;
            if (col_last) begin
              col_nxt  = '0;
              emit_nxt = 1'b1;
            end else begin
              col_nxt = col_r + AW'(1);
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (col_last) begin
            state_nxt = S_LOAD;
            cnt_nxt   = '0;
            qp_nxt    = '0;
            max_nxt   = 16'h8000;
          end else begin
            col_nxt   = col_r + AW'(1);
            state_nxt = S_READ;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      qp_r    <= '0;
      max_r   <= 16'h8000;
      col_r   <= '0;
      emit_r  <= 1'b0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      qp_r    <= qp_nxt;
      max_r   <= max_nxt;
      col_r   <= col_nxt;
      emit_r  <= emit_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      prob_r <= quo;
    end
  end

  assign out_valid       = (state_r == S_OUT);
  assign out_probability = prob_r;
  assign out_column      = COL_W'(col_r);
  assign out_last_weight = col_last;

endmodule

// ===== hw/rtl/csm_checker.sv =====
// Port-level checks for the causal masked softmax row core.
// Depends on csm_pkg for widths; bound to the top level below.
module csm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [csm_pkg::PROB_W-1:0] out_probability,
  input logic                       out_last_weight
);
  import csm_pkg::*;

  a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a weight is pending");

  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_probability <= 17'd65536))
    else $error("weight above one");

  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_weight) |=> !out_valid)
    else $error("weight after row end");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_probability)))
    else $error("stalled transaction changed");

endmodule

bind causal_masked_softmax_row_core csm_checker u_csm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_probability (out_probability),
  .out_last_weight (out_last_weight)
);
